// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the checker file of this core.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, ignored while reset is asserted.
`define CSQ_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, ignored while reset is asserted.
`define CSQ_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that is also checked during reset.
`define CSQ_ASSERT_NXT_ALWAYS(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/csq_pkg.sv =====
// Shared types, sizes and codes of the semaphore wait-queue core.
// No dependencies; the other files of the core, apart from assert_macros.svh, refer to it by scoped names.
`default_nettype none

package csq_pkg;

    // Sizes of the queue and the counter.
    localparam int MAX_WAITERS = 16;
    localparam int COUNT_WIDTH = 16;
    localparam int PTR_W       = (MAX_WAITERS > 1) ? $clog2(MAX_WAITERS) : 1;
    localparam int OCC_W       = $clog2(MAX_WAITERS + 1);
    localparam int TAIL_W      = OCC_W + 1;

    // Fixed field widths on the ports.
    localparam int ID_W      = 4;
    localparam int STATUS_W  = 2;
    localparam int WCOUNT_W  = 5;
    localparam int CFG_W     = 16;
    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 16;

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

    // Operation selector.
    localparam logic OP_ACQUIRE = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STATUS_GRANTED  = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_QUEUED   = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_REJECTED = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_RELEASE  = 2'd3;

    // Controller states.
    typedef enum logic {
        CSQ_IDLE,
        CSQ_WAKE
    } csq_state_t;

    // One result item.
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                woken_valid;
        logic [ID_W-1:0]     woken_id;
        logic                woken_ticket;
        logic                count_saturated;
        logic [WCOUNT_W-1:0] waiter_count;
    } csq_result_t;

    // Access to the waiter ring memory.
    typedef struct packed {
        logic             we;
        logic [PTR_W-1:0] waddr;
        logic [ID_W-1:0]  wdata;
        logic             re;
        logic [PTR_W-1:0] raddr;
    } csq_mem_req_t;

endpackage

`default_nettype wire

// ===== rtl/core/counting_semaphore_wait_queue_core.sv =====
// Top level of the counting semaphore with a waiter queue.
// Depends on csq_pkg, csq_sem_ctrl and csq_ring_mem.
//
// Channel   Direction  tdata bits (low first)                       tuser
// s_        in         requester_id[3:0] lifo[4] handoff[5] pad       operation
// m_        out        woken_valid[0] woken_id[4:1] woken_ticket[5]   status[1:0]
//                      count_saturated[6] waiter_count[11:7] pad
// cfg_      in         cfg_wdata = initial_count, written when cfg_we is high
//
// Acquires and releases that wake nobody pass straight to the output register; a release that
// wakes a waiter waits in the wake state for the registered read of the waiter ring memory.
// A new item is taken while no wake is in progress and the output register is empty or being drained.
// Reset is synchronous: count 1, empty queue; the ring memory is not cleared.
// A stalled result holds in the output register and blocks further input.
`default_nettype none

module counting_semaphore_wait_queue_core (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // Configuration.
    input  wire logic                          cfg_we,
    input  wire logic [csq_pkg::CFG_W-1:0]     cfg_wdata,
    // Input stream.
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [csq_pkg::S_TDATA_W-1:0] s_tdata,  // requester_id, lifo, handoff
    input  wire logic                          s_tuser,  // operation
    // Result stream.
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // woken_valid, woken_id, woken_ticket, count_saturated, waiter_count
    output logic [csq_pkg::M_TDATA_W-1:0]      m_tdata,
    output logic [csq_pkg::STATUS_W-1:0]       m_tuser   // status
);

    csq_pkg::csq_mem_req_t    mem_req;
    csq_pkg::csq_result_t     res;
    logic                     res_valid;
    logic [csq_pkg::ID_W-1:0] rd_data;
    logic                     out_free;
    logic                     m_tvalid_reg;
    csq_pkg::csq_result_t     m_res_reg;

    assign out_free = !m_tvalid_reg || m_tready;

    csq_sem_ctrl u_ctrl (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .in_valid        (s_tvalid),
        .in_operation    (s_tuser),
        .in_requester_id (s_tdata[csq_pkg::ID_W-1:0]),
        .in_lifo         (s_tdata[csq_pkg::ID_W]),
        .in_handoff      (s_tdata[csq_pkg::ID_W+1]),
        .out_free        (out_free),
        .rd_data         (rd_data),
        .in_ready        (s_tready),
        .res_valid       (res_valid),
        .res             (res),
        .mem_req         (mem_req)
    );

    csq_ring_mem u_ring (
        .aclk    (aclk),
        .mem_req (mem_req),
        .rd_data (rd_data)
    );

    // Output register valid flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (res_valid) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    // Output register payload.
    always_ff @(posedge aclk) begin
        if (res_valid) begin
            m_res_reg <= res;
        end
    end

    // Pack the result onto the stream.
    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_res_reg.status;
    assign m_tdata  = {4'b0000, m_res_reg.waiter_count, m_res_reg.count_saturated,
                       m_res_reg.woken_ticket, m_res_reg.woken_id, m_res_reg.woken_valid};

endmodule

`default_nettype wire

// ===== rtl/core/csq_ring_mem.sv =====
// Waiter ring storage: one write port and one registered read port.
// Depends on csq_pkg for the depth and the request type.
`default_nettype none

module csq_ring_mem (
    input  wire logic                  aclk,
    input  wire csq_pkg::csq_mem_req_t mem_req,
    output logic [csq_pkg::ID_W-1:0]   rd_data
);

    logic [csq_pkg::ID_W-1:0] mem [csq_pkg::MAX_WAITERS];
    logic [csq_pkg::ID_W-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge aclk) begin
        if (mem_req.we) begin
            mem[mem_req.waddr] <= mem_req.wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge aclk) begin
        if (mem_req.re) begin
            rd_data_reg <= mem[mem_req.raddr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== rtl/core/csq_sem_ctrl.sv =====
// Semaphore controller: count, ring pointers, occupancy and the wake sequencer.
// Depends on csq_pkg; drives the waiter ring memory through csq_mem_req_t.
`default_nettype none

module csq_sem_ctrl (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     cfg_we,
    input  wire logic [csq_pkg::CFG_W-1:0] cfg_wdata,
    input  wire logic                     in_valid,
    input  wire logic                     in_operation,
    input  wire logic [csq_pkg::ID_W-1:0] in_requester_id,
    input  wire logic                     in_lifo,
    input  wire logic                     in_handoff,
    input  wire logic                     out_free,
    input  wire logic [csq_pkg::ID_W-1:0] rd_data,
    output logic                          in_ready,
    output logic                          res_valid,
    output csq_pkg::csq_result_t          res,
    output csq_pkg::csq_mem_req_t         mem_req
);

    csq_pkg::csq_state_t state_reg, state_next;

    logic [csq_pkg::COUNT_WIDTH-1:0] sem_count_reg, sem_count_next;
    logic [csq_pkg::PTR_W-1:0]       ring_head_reg, ring_head_next;
    logic [csq_pkg::OCC_W-1:0]       ring_occ_reg, ring_occ_next;
    csq_pkg::csq_result_t            pending_reg;

    logic                            accept;
    logic                            needs_read;
    csq_pkg::csq_result_t            res_now;
    logic [csq_pkg::PTR_W-1:0]       head_dec;
    logic [csq_pkg::PTR_W-1:0]       head_inc;
    logic [csq_pkg::TAIL_W-1:0]      tail_sum;
    logic [csq_pkg::PTR_W-1:0]       tail_pos;
    logic [csq_pkg::COUNT_WIDTH-1:0] count_up;
    logic                            at_max;

    assign accept = in_valid && in_ready;

    // Ring positions around the head, wrapped at the queue depth, and the saturating count increment.
    always_comb begin
        head_dec = (ring_head_reg == '0) ? csq_pkg::PTR_W'(csq_pkg::MAX_WAITERS - 1)
                                         : ring_head_reg - csq_pkg::PTR_W'(1);
        head_inc = (ring_head_reg == csq_pkg::PTR_W'(csq_pkg::MAX_WAITERS - 1)) ? '0
                                         : ring_head_reg + csq_pkg::PTR_W'(1);
        tail_sum = csq_pkg::TAIL_W'(ring_head_reg) + csq_pkg::TAIL_W'(ring_occ_reg);
        if (tail_sum >= csq_pkg::TAIL_W'(csq_pkg::MAX_WAITERS)) begin
            tail_pos = csq_pkg::PTR_W'(tail_sum - csq_pkg::TAIL_W'(csq_pkg::MAX_WAITERS));
        end else begin
            tail_pos = csq_pkg::PTR_W'(tail_sum);
        end
        at_max   = (sem_count_reg == csq_pkg::COUNT_MAX);
        count_up = at_max ? csq_pkg::COUNT_MAX
                          : sem_count_reg + csq_pkg::COUNT_WIDTH'(1);
    end

    // Item decode: next state of the count and the ring, and the result.
    always_comb begin
        sem_count_next = sem_count_reg;
        ring_head_next = ring_head_reg;
        ring_occ_next  = ring_occ_reg;
        needs_read     = 1'b0;
        mem_req        = '0;
        res_now        = '0;

        if (accept) begin
            if (in_operation == csq_pkg::OP_ACQUIRE) begin
                if (sem_count_reg != '0) begin
                    sem_count_next = sem_count_reg - csq_pkg::COUNT_WIDTH'(1);
                    res_now.status = csq_pkg::STATUS_GRANTED;
                end else if (ring_occ_reg >= csq_pkg::OCC_W'(csq_pkg::MAX_WAITERS)) begin
                    res_now.status = csq_pkg::STATUS_REJECTED;
                end else begin
                    mem_req.we    = 1'b1;
                    mem_req.wdata = in_requester_id;
                    if (in_lifo) begin
                        mem_req.waddr  = head_dec;
                        ring_head_next = head_dec;
                    end else begin
                        mem_req.waddr = tail_pos;
                    end
                    ring_occ_next  = ring_occ_reg + csq_pkg::OCC_W'(1);
                    res_now.status = csq_pkg::STATUS_QUEUED;
                end
            end else begin
                res_now.status          = csq_pkg::STATUS_RELEASE;
                res_now.count_saturated = at_max;
                sem_count_next          = count_up;
                if (ring_occ_reg != '0) begin
                    needs_read          = 1'b1;
                    mem_req.re          = 1'b1;
                    mem_req.raddr       = ring_head_reg;
                    ring_head_next      = head_inc;
                    ring_occ_next       = ring_occ_reg - csq_pkg::OCC_W'(1);
                    res_now.woken_valid = 1'b1;
                    if (in_handoff && (count_up != '0)) begin
                        sem_count_next       = count_up - csq_pkg::COUNT_WIDTH'(1);
                        res_now.woken_ticket = 1'b1;
                    end
                end
            end
            res_now.waiter_count = csq_pkg::WCOUNT_W'(ring_occ_next);
        end

        // A configuration write loads the count directly.
        if (cfg_we) begin
            sem_count_next = csq_pkg::COUNT_WIDTH'(cfg_wdata);
        end
    end

    // Next state of the wake sequencer.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            csq_pkg::CSQ_IDLE: begin
                if (accept && needs_read) begin
                    state_next = csq_pkg::CSQ_WAKE;
                end
            end
            csq_pkg::CSQ_WAKE: begin
                state_next = csq_pkg::CSQ_IDLE;
            end
            default: begin
                state_next = csq_pkg::CSQ_IDLE;
            end
        endcase
    end

    // Sequencer outputs: ready and the result toward the output register.
    always_comb begin
        in_ready  = 1'b0;
        res_valid = 1'b0;
        res       = res_now;
        unique case (state_reg)
            csq_pkg::CSQ_IDLE: begin
                in_ready  = out_free;
                res_valid = accept && !needs_read;
            end
            csq_pkg::CSQ_WAKE: begin
                res_valid    = 1'b1;
                res          = pending_reg;
                res.woken_id = rd_data;
            end
            default: begin
                in_ready  = 1'b0;
                res_valid = 1'b0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= csq_pkg::CSQ_IDLE;
            sem_count_reg <= csq_pkg::COUNT_WIDTH'(1);
            ring_head_reg <= '0;
            ring_occ_reg  <= '0;
        end else begin
            state_reg     <= state_next;
            sem_count_reg <= sem_count_next;
            ring_head_reg <= ring_head_next;
            ring_occ_reg  <= ring_occ_next;
        end
    end

    // The release result waits here while the ring entry is read.
    always_ff @(posedge aclk) begin
        if (accept && needs_read) begin
            pending_reg <= res_now;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/csq_checker.sv =====
// Port-level checks of the semaphore core and the bind that attaches them.
// Depends on csq_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module csq_checker (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          m_tvalid,
    input wire logic                          m_tready,
    input wire logic [csq_pkg::M_TDATA_W-1:0] m_tdata,
    input wire logic [csq_pkg::STATUS_W-1:0]  m_tuser
);

    // A stalled result keeps its contents.
    `CSQ_ASSERT_NXT(a_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

    // Reset empties the output register.
    `CSQ_ASSERT_NXT_ALWAYS(a_reset_empty, aclk, !aresetn, !m_tvalid, "result valid after reset")

    // Acquire results never wake anyone nor report saturation.
    `CSQ_ASSERT_IMP(a_acq_quiet, aclk, aresetn, m_tvalid && (m_tuser != csq_pkg::STATUS_RELEASE), m_tdata[6:0] == 7'd0, "acquire result carries wake or saturation")

    // Without a woken waiter there is neither an id nor a ticket.
    `CSQ_ASSERT_IMP(a_no_wake, aclk, aresetn, m_tvalid && !m_tdata[0], m_tdata[5:1] == 5'd0, "wake fields set without a woken waiter")

endmodule

bind counting_semaphore_wait_queue_core csq_checker u_csq_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire
